// ===== hw/rtl/gbn_pkg.sv =====
package gbn_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int SEQ_BITS     = 16;

  localparam int WIN_W = $clog2(WINDOW_DEPTH);
  localparam int SEQ_W = SEQ_BITS;
  // compare width for occupancy vs. the 5-bit window limit
  localparam int CMP_W = (WIN_W > 5) ? WIN_W : 5;

  localparam logic [SEQ_W-1:0] SEQ_HALF = SEQ_W'(((64'd1 << SEQ_BITS) - 64'd1) >> 1);
  localparam int MAX_RESULTS = 31;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // input kinds
  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_DATA    = 3'd1;
  localparam logic [2:0] K_ACK     = 3'd2;
  localparam logic [2:0] K_RTX_REQ = 3'd3;
  localparam logic [2:0] K_TIMEOUT = 3'd4;
  localparam logic [2:0] K_HB      = 3'd5;
  localparam logic [2:0] K_HB_ACK  = 3'd6;
  localparam logic [2:0] K_NONE    = 3'd7;

  // result actions
  localparam logic [2:0] A_DROP    = 3'd0;
  localparam logic [2:0] A_TX      = 3'd1;
  localparam logic [2:0] A_ACK     = 3'd2;
  localparam logic [2:0] A_RTX_REQ = 3'd3;
  localparam logic [2:0] A_HB      = 3'd4;
  localparam logic [2:0] A_HB_ACK  = 3'd5;
  localparam logic [2:0] A_ACCEPT  = 3'd6;
  localparam logic [2:0] A_NOTHING = 3'd7;

  // retransmit timer commands
  localparam logic [1:0] TMR_LEAVE   = 2'd0;
  localparam logic [1:0] TMR_RESTART = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;

  // link status codes
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_DOWN    = 2'd1;
  localparam logic [1:0] ST_UP      = 2'd2;

  // configuration register indexes
  localparam logic REG_WINDOW_LIMIT = 1'b0;
  localparam logic REG_MAX_RETRANS  = 1'b1;

  typedef struct packed {
    logic [2:0]       action;
    logic [SEQ_W-1:0] seq;
    logic [WIN_W-1:0] slot;
    logic [1:0]       timer;
    logic             done;
    logic [1:0]       status;
    logic             last;
  } res_t;

endpackage

// ===== hw/rtl/go_back_n_link_sequencer_core.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  kind, hdr_seq, is_first, is_last, msg_number
// out_     output     out_valid/out_stall action, seq_out, slot, timer_cmd, message_done,
//                                         status_sent, last
// cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// An item goes through acceptance, two passes through the
// shared sequence subtractor (ack distance, receive distance), then decode, before its first result.
// A second result (S_PEND) and each slot of a retransmit run (S_RUN) follow in their own states.
// in_stall is high from acceptance until the final result is loaded into the output register.
// Reset restores all link state at once; there is no clearing pass.
// out_stall holds the output register and stalls the sequencer in S_EXEC, S_PEND and S_RUN until it frees.
module go_back_n_link_sequencer_core
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_hdr_seq,
  input  logic        in_is_first,
  input  logic        in_is_last,
  input  logic [31:0] in_msg_number,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [15:0] out_seq_out,
  output logic [4:0]  out_slot,
  output logic [1:0]  out_timer_cmd,
  output logic        out_message_done,
  output logic [1:0]  out_status_sent,
  output logic        out_last,

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_BACK, S_DIFF, S_EXEC, S_PEND, S_RUN} state_t;

  state_t state_r, state_nxt;

  logic [4:0]       win_limit_r, win_limit_nxt;
  logic [7:0]       max_retrans_r, max_retrans_nxt;

  logic [SEQ_W-1:0] tx_next_r, tx_next_nxt;
  logic [WIN_W-1:0] win_head_r, win_head_nxt;
  logic [WIN_W-1:0] win_tail_r, win_tail_nxt;
  logic [7:0]       tmo_cnt_r, tmo_cnt_nxt;
  logic [SEQ_W-1:0] rx_exp_r, rx_exp_nxt;
  logic [SEQ_W-1:0] req_seq_r, req_seq_nxt;
  logic [1:0]       own_st_r, own_st_nxt;
  logic [1:0]       peer_st_r, peer_st_nxt;
  logic             in_open_r, in_open_nxt;
  logic [31:0]      cur_num_r, cur_num_nxt;

  // latched item
  logic [2:0]       kind_r, kind_nxt;
  logic [SEQ_W-1:0] fseq_r, fseq_nxt;
  logic             first_r, first_nxt;
  logic             lastf_r, lastf_nxt;
  logic [31:0]      mnum_r, mnum_nxt;

  logic [SEQ_W-1:0] back_r, back_nxt;
  logic [SEQ_W-1:0] diff_r, diff_nxt;

  logic [WIN_W-1:0] run_slot_r, run_slot_nxt;
  logic [CNT_W-1:0] run_cnt_r, run_cnt_nxt;
  logic [1:0]       run_tcmd_r, run_tcmd_nxt;

  res_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             pend_r, pend_nxt;
  res_t             res;

  // shared sequence subtractor
  logic [SEQ_W-1:0] sub_a, sub_b, sub_y;

  logic             out_free;
  logic [WIN_W-1:0] used;
  logic             back_ok;
  logic [WIN_W-1:0] ack_idx;
  logic [WIN_W-1:0] run_back;
  logic             run_final;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign used     = win_tail_r - win_head_r;
  assign back_ok  = (back_r != '0) && (back_r <= SEQ_W'(used));
  assign ack_idx  = win_tail_r - back_r[WIN_W-1:0];
  assign run_back = win_tail_r - run_slot_r;
  assign run_final = ((run_slot_r + 1'b1) == win_tail_r) ||
                     (run_cnt_r == CNT_W'(MAX_RESULTS - 1));

  always_comb begin
    case (state_r)
      S_BACK: begin
        sub_a = tx_next_r;
        sub_b = fseq_r;
      end
      S_DIFF: begin
        sub_a = fseq_r;
        sub_b = rx_exp_r;
      end
      S_RUN: begin
        sub_a = tx_next_r;
        sub_b = SEQ_W'(run_back);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_y = sub_a - sub_b;

  always_comb begin
    state_nxt       = state_r;
    win_limit_nxt   = win_limit_r;
    max_retrans_nxt = max_retrans_r;
    tx_next_nxt     = tx_next_r;
    win_head_nxt    = win_head_r;
    win_tail_nxt    = win_tail_r;
    tmo_cnt_nxt     = tmo_cnt_r;
    rx_exp_nxt      = rx_exp_r;
    req_seq_nxt     = req_seq_r;
    own_st_nxt      = own_st_r;
    peer_st_nxt     = peer_st_r;
    in_open_nxt     = in_open_r;
    cur_num_nxt     = cur_num_r;
    kind_nxt        = kind_r;
    fseq_nxt        = fseq_r;
    first_nxt       = first_r;
    lastf_nxt       = lastf_r;
    mnum_nxt        = mnum_r;
    back_nxt        = back_r;
    diff_nxt        = diff_r;
    run_slot_nxt    = run_slot_r;
    run_cnt_nxt     = run_cnt_r;
    run_tcmd_nxt    = run_tcmd_r;
    out_nxt         = out_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && out_stall;

    res        = '0;
    res.action = A_DROP;
    res.last   = 1'b1;

    if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LIMIT: win_limit_nxt   = cfg_wdata[4:0];
        REG_MAX_RETRANS:  max_retrans_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // data, ack and retransmit request need the link up
          if ((in_kind == K_DATA || in_kind == K_ACK || in_kind == K_RTX_REQ) &&
              own_st_r != ST_UP)
            kind_nxt = K_NONE;
          else
            kind_nxt = in_kind;
          fseq_nxt  = SEQ_W'(in_hdr_seq);
          first_nxt = in_is_first;
          lastf_nxt = in_is_last;
          mnum_nxt  = in_msg_number;
          state_nxt = S_BACK;
        end
      end

      S_BACK: begin
        back_nxt  = sub_y;
        state_nxt = S_DIFF;
      end

      S_DIFF: begin
        diff_nxt  = sub_y;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          case (kind_r)
            K_SEND: begin
              if (CMP_W'(used) < CMP_W'(win_limit_r)) begin
                res.action   = A_TX;
                res.seq      = tx_next_r;
                res.slot     = win_tail_r;
                res.timer    = (win_head_r == win_tail_r) ? TMR_RESTART : TMR_LEAVE;
                tx_next_nxt  = tx_next_r + 1'b1;
                win_tail_nxt = win_tail_r + 1'b1;
              end
            end

            K_DATA: begin
              if (diff_r == '0) begin
                res.action  = A_ACK;
                res.seq     = fseq_r;
                res.last    = 1'b0;
                rx_exp_nxt  = rx_exp_r + 1'b1;
                req_seq_nxt = '0;
                pend_nxt        = '0;
                pend_nxt.last   = 1'b1;
                pend_nxt.action = A_DROP;
                if (first_r || (in_open_r && cur_num_r == mnum_r)) begin
                  pend_nxt.action = A_ACCEPT;
                  pend_nxt.seq    = fseq_r;
                  pend_nxt.done   = lastf_r;
                  in_open_nxt     = !lastf_r;
                  if (first_r)
                    cur_num_nxt = mnum_r;
                end
                state_nxt = S_PEND;
              end else if (diff_r <= SEQ_HALF) begin
                // ahead of order: one request per gap
                if (req_seq_r != rx_exp_r) begin
                  res.action  = A_RTX_REQ;
                  res.seq     = rx_exp_r;
                  req_seq_nxt = rx_exp_r;
                end else begin
                  res.action = A_NOTHING;
                end
              end else begin
                res.action = A_ACK;
                res.seq    = fseq_r;
              end
            end

            K_ACK: begin
              if (back_ok) begin
                res.action   = A_NOTHING;
                win_head_nxt = ack_idx + 1'b1;
                tmo_cnt_nxt  = '0;
                res.timer    = ((ack_idx + 1'b1) != win_tail_r) ? TMR_RESTART : TMR_STOP;
              end
            end

            K_RTX_REQ: begin
              if (back_ok) begin
                run_slot_nxt = ack_idx;
                run_cnt_nxt  = '0;
                run_tcmd_nxt = TMR_LEAVE;
                state_nxt    = S_RUN;
              end else begin
                res.action = A_HB;
                res.seq    = tx_next_r;
                res.status = own_st_r;
              end
            end

            K_TIMEOUT: begin
              res.action = A_NOTHING;
              res.timer  = (win_head_r != win_tail_r) ? TMR_RESTART : TMR_LEAVE;
              if (tmo_cnt_r < max_retrans_r) begin
                tmo_cnt_nxt = tmo_cnt_r + 1'b1;
                if (win_head_r != win_tail_r) begin
                  run_slot_nxt = win_head_r;
                  run_cnt_nxt  = '0;
                  run_tcmd_nxt = TMR_RESTART;
                  state_nxt    = S_RUN;
                end
              end else begin
                peer_st_nxt = ST_DOWN;
                tmo_cnt_nxt = '0;
              end
            end

            K_HB: begin
              rx_exp_nxt  = fseq_r;
              peer_st_nxt = ST_UP;
              own_st_nxt  = ST_UP;
              res.action  = A_HB_ACK;
              res.seq     = tx_next_r;
              res.status  = own_st_r;
            end

            K_HB_ACK: begin
              rx_exp_nxt  = fseq_r;
              own_st_nxt  = ST_UP;
              peer_st_nxt = (mnum_r <= 32'd2) ? mnum_r[1:0] : ST_UNKNOWN;
              if (mnum_r == 32'(ST_UP)) begin
                res.action = A_NOTHING;
              end else begin
                res.action = A_HB;
                res.seq    = tx_next_r;
                res.status = ST_UP;
              end
            end

            default: ;
          endcase
          if (state_nxt != S_RUN) begin
            out_nxt       = res;
            out_valid_nxt = 1'b1;
          end
        end
      end

      S_PEND: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_RUN: begin
        if (out_free) begin
          res.action    = A_TX;
          res.seq       = sub_y;
          res.slot      = run_slot_r;
          res.timer     = run_final ? run_tcmd_r : TMR_LEAVE;
          res.last      = run_final;
          out_nxt       = res;
          out_valid_nxt = 1'b1;
          run_slot_nxt  = run_slot_r + 1'b1;
          run_cnt_nxt   = run_cnt_r + 1'b1;
          if (run_final)
            state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      win_limit_r   <= 5'd31;
      max_retrans_r <= 8'd3;
      tx_next_r     <= '0;
      win_head_r    <= '0;
      win_tail_r    <= '0;
      tmo_cnt_r     <= '0;
      rx_exp_r      <= '0;
      req_seq_r     <= '0;
      own_st_r      <= ST_DOWN;
      peer_st_r     <= ST_UNKNOWN;
      in_open_r     <= 1'b0;
      cur_num_r     <= '0;
      out_valid_r   <= 1'b0;
      kind_r        <= K_NONE;
      fseq_r        <= '0;
      first_r       <= 1'b0;
      lastf_r       <= 1'b0;
      mnum_r        <= '0;
      back_r        <= '0;
      diff_r        <= '0;
      run_slot_r    <= '0;
      run_cnt_r     <= '0;
      run_tcmd_r    <= TMR_LEAVE;
      out_r         <= '0;
      pend_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      win_limit_r   <= win_limit_nxt;
      max_retrans_r <= max_retrans_nxt;
      tx_next_r     <= tx_next_nxt;
      win_head_r    <= win_head_nxt;
      win_tail_r    <= win_tail_nxt;
      tmo_cnt_r     <= tmo_cnt_nxt;
      rx_exp_r      <= rx_exp_nxt;
      req_seq_r     <= req_seq_nxt;
      own_st_r      <= own_st_nxt;
      peer_st_r     <= peer_st_nxt;
      in_open_r     <= in_open_nxt;
      cur_num_r     <= cur_num_nxt;
      out_valid_r   <= out_valid_nxt;
      kind_r        <= kind_nxt;
      fseq_r        <= fseq_nxt;
      first_r       <= first_nxt;
      lastf_r       <= lastf_nxt;
      mnum_r        <= mnum_nxt;
      back_r        <= back_nxt;
      diff_r        <= diff_nxt;
      run_slot_r    <= run_slot_nxt;
      run_cnt_r     <= run_cnt_nxt;
      run_tcmd_r    <= run_tcmd_nxt;
      out_r         <= out_nxt;
      pend_r        <= pend_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_r.action;
  assign out_seq_out      = 16'(out_r.seq);
  assign out_slot         = 5'(out_r.slot);
  assign out_timer_cmd    = out_r.timer;
  assign out_message_done = out_r.done;
  assign out_status_sent  = out_r.status;
  assign out_last         = out_r.last;

  // a non-final beat means the sequencer still owes results
  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> (state_r != S_IDLE))
    else $error("non-final beat with sequencer idle");

  // only a retransmit run holds non-final transmit beats
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == A_TX && !out_last) |-> (state_r == S_RUN))
    else $error("run ended without a final beat");

  // a run never walks onto the free tail slot
  a_run_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (run_slot_r != win_tail_r))
    else $error("retransmit run reached the tail");

endmodule
